// File: design/escaped_length_frame_parser_macros.svh
// ---------------------------------------------------------------------------
// escaped_length_frame_parser_macros.svh
// Assertion macros for the escaped length frame parser. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_LENGTH_FRAME_PARSER_MACROS_SVH
`define ESCAPED_LENGTH_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define ELFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising clock edge out of reset.
`define ELFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ELFP_ASSERT_NOW(lbl, ante, cons, msg)
`define ELFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/elfp_pkg.sv
// ---------------------------------------------------------------------------
// elfp_pkg
// Types and constants shared by the escaped length frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package elfp_pkg;

  // Number of little-endian bytes in the frame length prefix (1 to 4).
  localparam int LEN_BYTES = 4;
  localparam int LEN_W     = 8 * LEN_BYTES;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_MARKER = 2'd1;
  localparam logic [1:0] CFG_LENGTH_LIMIT  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  START_MARKER_RST  = 8'd126;
  localparam logic [7:0]  ESCAPE_MARKER_RST = 8'd125;
  localparam logic [15:0] LENGTH_LIMIT_RST  = 16'd256;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_LAST     = 2'd1,
    KIND_ABANDON  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

endpackage

// File: design/escaped_length_frame_parser.sv
// ---------------------------------------------------------------------------
// escaped_length_frame_parser
// Receive-side deframer for byte-stuffed, length-prefixed serial frames.
// ---------------------------------------------------------------------------
// Takes one received byte per item and returns at most one result per byte.
// An unescaped start marker opens a frame; the next LEN_BYTES unescaped bytes
// give a little-endian length counted in wire bytes (escapes included). A
// length at or above length_limit drops the frame with an overflow result
// carrying the length saturated to 16 bits; a zero length ends the frame
// silently. Each data byte comes out with its offset, and the byte at which
// the wire count reaches the length is marked last and carries the length.
// A start marker inside a frame reports an abandon result and restarts. An
// escape byte makes the next byte literal; an escaped escape is literal and
// does not escape the byte after it. Throughput is one byte per clock unless a
// byte with a result waits in the input register for a full result register.
// A byte goes from the input register through the parse logic into the result
// register; the parse state is updated once per byte in a single step. Bytes
// that give no result never wait on out_tready. in_tready depends combinationally
// on out_tready. Configuration is to be written by the user only while idle;
// the block itself does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "escaped_length_frame_parser_macros.svh"

module escaped_length_frame_parser
  import elfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // received byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] payload_byte, [23:8] byte_offset,
                                  // [39:24] frame_length
  output logic [1:0]  out_tuser   // [1:0] kind
);

  // configuration registers
  logic [7:0]  start_marker_r;
  logic [7:0]  escape_marker_r;
  logic [15:0] length_limit_r;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  // parse state
  phase_t      phase_r,     phase_nxt;
  logic        esc_pend_r,  esc_pend_nxt;
  logic [15:0] field_cnt_r, field_cnt_nxt;
  logic [15:0] skip_cnt_r,  skip_cnt_nxt;
  logic [LEN_W-1:0] len_word_r, len_word_nxt;

  // result register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_off_r;
  logic [15:0] out_len_r;

  // parse logic outputs
  logic        is_esc;
  logic        is_start;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic [15:0] res_off;
  logic [15:0] res_len;
  logic [LEN_W-1:0] lw_ins;
  logic [31:0] lw32_ins;
  logic [31:0] lw32_cur;
  logic [15:0] fc_inc;
  logic [16:0] data_sum;

  logic        out_free;
  logic        s1_adv;

  // -------------------------------------------------------------------------
  // Handshake: the input register advances when its result (if any) has a
  // free slot in the result register.
  // -------------------------------------------------------------------------
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (out_free || !res_valid);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_len_r, out_off_r, out_byte_r};

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r  <= START_MARKER_RST;
      escape_marker_r <= ESCAPE_MARKER_RST;
      length_limit_r  <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER:  start_marker_r  <= cfg_wdata[7:0];
        CFG_ESCAPE_MARKER: escape_marker_r <= cfg_wdata[7:0];
        CFG_LENGTH_LIMIT:  length_limit_r  <= cfg_wdata;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input register: hold the byte until the parse step takes it.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[7:0];
    end
  end

  // -------------------------------------------------------------------------
  // Parse step: one byte against the current state.
  // -------------------------------------------------------------------------
  assign lw32_cur = 32'(len_word_r);
  assign lw32_ins = 32'(lw_ins);
  assign fc_inc   = field_cnt_r + 16'd1;
  assign data_sum = {1'b0, fc_inc} + {1'b0, skip_cnt_r};

  always_comb begin
    lw_ins = len_word_r;
    for (int i = 0; i < LEN_BYTES; i++) begin
      if (field_cnt_r == 16'(i)) begin
        lw_ins[8*i +: 8] = len_word_r[8*i +: 8] | s1_byte_r;
      end
    end
  end

  always_comb begin
    is_esc   = (s1_byte_r == escape_marker_r) && !esc_pend_r;
    is_start = !esc_pend_r && (s1_byte_r == start_marker_r);

    phase_nxt     = phase_r;
    esc_pend_nxt  = esc_pend_r;
    field_cnt_nxt = field_cnt_r;
    skip_cnt_nxt  = skip_cnt_r;
    len_word_nxt  = len_word_r;

    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = 8'd0;
    res_off   = 16'd0;
    res_len   = 16'd0;

    if (is_start) begin
      // Restart: report the frame in progress as abandoned.
      if (phase_r == PH_LEN || phase_r == PH_DATA) begin
        res_valid = 1'b1;
        res_kind  = KIND_ABANDON;
      end
      phase_nxt     = PH_LEN;
      field_cnt_nxt = 16'd0;
      skip_cnt_nxt  = 16'd0;
      len_word_nxt  = '0;
      esc_pend_nxt  = 1'b0;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          // Escapes inside the length prefix are skipped and not counted.
          if (!is_esc) begin
            len_word_nxt = lw_ins;
            if (fc_inc >= 16'(LEN_BYTES)) begin
              field_cnt_nxt = 16'd0;
              skip_cnt_nxt  = 16'd0;
              if (lw32_ins >= {16'd0, length_limit_r}) begin
                res_valid = 1'b1;
                res_kind  = KIND_OVERFLOW;
                res_len   = (lw32_ins > 32'h0000_FFFF) ? 16'hFFFF : lw32_ins[15:0];
                phase_nxt = PH_WAIT;
              end else if (lw32_ins == 32'd0) begin
                phase_nxt = PH_WAIT;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else begin
              field_cnt_nxt = fc_inc;
            end
          end
        end
        PH_DATA: begin
          if (!is_esc) begin
            res_valid = 1'b1;
            res_byte  = s1_byte_r;
            res_off   = field_cnt_r;
            // Close the frame once payload plus skipped escapes reach the length.
            if (32'(data_sum) >= lw32_cur) begin
              res_kind      = KIND_LAST;
              res_len       = lw32_cur[15:0];
              phase_nxt     = PH_WAIT;
              field_cnt_nxt = 16'd0;
            end else begin
              field_cnt_nxt = fc_inc;
            end
          end else begin
            skip_cnt_nxt = skip_cnt_r + 16'd1;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
      esc_pend_nxt = is_esc;
    end
  end

  // Advance the parse state only when the byte leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      esc_pend_r  <= 1'b0;
      field_cnt_r <= 16'd0;
      skip_cnt_r  <= 16'd0;
      len_word_r  <= '0;
    end else if (s1_adv) begin
      phase_r     <= phase_nxt;
      esc_pend_r  <= esc_pend_nxt;
      field_cnt_r <= field_cnt_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
      len_word_r  <= len_word_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Result register: load a new result, drop it once taken.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_off_r  <= res_off;
      out_len_r  <= res_len;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ELFP_ASSERT_NOW(a_ctrl_result_clean,
    out_valid_r && (out_kind_r == KIND_ABANDON || out_kind_r == KIND_OVERFLOW),
    out_byte_r == 8'd0 && out_off_r == 16'd0, "control result carries payload data")
  `ELFP_ASSERT_NEXT(a_stall_holds_byte,
    s1_valid_r && res_valid && out_valid_r && !out_tready,
    s1_valid_r && $stable(s1_byte_r), "pending byte lost while result stalled")
  `ELFP_ASSERT_NEXT(a_last_closes_frame,
    s1_adv && res_valid && res_kind == KIND_LAST,
    phase_r == PH_WAIT && field_cnt_r == 16'd0, "frame not closed after last byte")
  `ELFP_ASSERT_NEXT(a_start_opens_frame,
    s1_adv && is_start,
    phase_r == PH_LEN && !esc_pend_r && len_word_r == '0, "start marker did not open frame")

endmodule

// File: test/escaped_length_frame_parser_test.sv
// ----------------------------------------------------------------------------
// escaped_length_frame_parser_test
// Self-checking bench for the byte-stuffed, length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// A short stimulus table runs first at the reset settings. It covers escapes
// while idle, an escaped start marker, an escape inside the length, an escaped
// escape, a restart in the data phase, overflow and a zero length. Random
// traffic follows under several marker and limit settings, the extremes
// included. It is mostly well-formed frames with random content, plus broken
// lengths, cut-off frames and line noise. A predictor in the bench tracks the
// parse state and queues the result of every accepted byte. Each result is
// then compared field by field against the oldest queued one. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_length_frame_parser_test;
  import elfp_pkg::*;

  localparam int STALL_LIMIT     = 500;  // cycles without any handshake
  localparam int DRAIN_CYCLES    = 6;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 300;

  // One result item as the bench sees it: the kind and the three tdata fields.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [15:0] offset;
    logic [15:0] length;
  } frame_result_t;

  // How a stimulus row gets its expectation: from the predictor, typed in as
  // "no result", or typed in as a given result.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_GIVEN
  } row_mode_t;

  typedef struct packed {
    logic [7:0]    rx;
    row_mode_t     mode;
    frame_result_t given;
  } script_row_t;

  localparam frame_result_t NO_RESULT = '0;
  localparam int N_ROWS = 28;

  // Directed rows, all at the reset markers (start 7E, escape 7D, limit 256).
  localparam script_row_t SCRIPT [N_ROWS] = '{
    // idle line: an escape, then an escaped start marker, then a real start
    '{8'h7D, ROW_NONE,    NO_RESULT},
    '{8'h7E, ROW_NONE,    NO_RESULT},
    '{8'h7E, ROW_NONE,    NO_RESULT},
    // length 4, with an escape skipped inside the length field
    '{8'h04, ROW_PREDICT, NO_RESULT},
    '{8'h7D, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    // data: FF, then an escaped escape that must not escape the next byte,
    // so the following start marker abandons the frame
    '{8'hFF, ROW_PREDICT, NO_RESULT},
    '{8'h7D, ROW_PREDICT, NO_RESULT},
    '{8'h7D, ROW_PREDICT, NO_RESULT},
    '{8'h7E, ROW_GIVEN,   '{KIND_ABANDON, 8'h00, 16'h0000, 16'h0000}},
    // length 2; one escaped start marker fills it with the escape counted
    '{8'h02, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h7D, ROW_PREDICT, NO_RESULT},
    '{8'h7E, ROW_PREDICT, NO_RESULT},
    // all-ones length: overflow with the length saturated
    '{8'h7E, ROW_NONE,    NO_RESULT},
    '{8'hFF, ROW_PREDICT, NO_RESULT},
    '{8'hFF, ROW_PREDICT, NO_RESULT},
    '{8'hFF, ROW_PREDICT, NO_RESULT},
    '{8'hFF, ROW_GIVEN,   '{KIND_OVERFLOW, 8'h00, 16'h0000, 16'hFFFF}},
    // zero length: the frame closes silently
    '{8'h7E, ROW_NONE,    NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_PREDICT, NO_RESULT},
    '{8'h00, ROW_NONE,    NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] payload_byte, [23:8] byte_offset,
                           // [39:24] frame_length
  logic [1:0]  out_tuser;  // [1:0] kind

  escaped_length_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow registers and parse state of the predictor.
  logic [7:0]  marker_start  = START_MARKER_RST;
  logic [7:0]  marker_escape = ESCAPE_MARKER_RST;
  logic [15:0] limit_len     = LENGTH_LIMIT_RST;
  phase_t      parse_state   = PH_WAIT;
  logic        esc_pending   = 1'b0;
  logic [15:0] count         = '0;
  logic [15:0] skips         = '0;
  logic [31:0] len_word      = '0;

  frame_result_t pending_results[$];
  int            mismatches  = 0;
  int            quiet_cycles = 0;
  bit            calm = 1'b0;  // while set, neither side idles

  // Advance the parse state by one received byte; report the result, if any.
  task automatic deframe_byte(input logic [7:0] rx, output bit got,
                              output frame_result_t r);
    logic literal;
    logic is_esc;
    got    = 1'b0;
    r      = NO_RESULT;
    literal = esc_pending;
    is_esc  = (rx == marker_escape) && !literal;
    if (!literal && rx == marker_start) begin
      // unescaped start: abandon any frame in progress and reopen
      if (parse_state != PH_WAIT) begin
        got    = 1'b1;
        r.kind = KIND_ABANDON;
      end
      parse_state = PH_LEN;
      count       = '0;
      skips       = '0;
      len_word    = '0;
      esc_pending = 1'b0;
    end else begin
      if (parse_state == PH_LEN) begin
        // escapes in the length are dropped and not counted
        if (!is_esc) begin
          len_word = len_word | (32'(rx) << (8 * count[1:0]));
          count    = count + 16'd1;
          if (count >= LEN_BYTES) begin
            count = '0;
            skips = '0;
            if (len_word >= {16'h0000, limit_len}) begin
              got         = 1'b1;
              r.kind      = KIND_OVERFLOW;
              r.length    = (len_word > 32'h0000_FFFF) ? 16'hFFFF : len_word[15:0];
              parse_state = PH_WAIT;
            end else if (len_word == '0) begin
              parse_state = PH_WAIT;
            end else begin
              parse_state = PH_DATA;
            end
          end
        end
      end else if (parse_state == PH_DATA) begin
        if (!is_esc) begin
          got       = 1'b1;
          r.payload = rx;
          r.offset  = count;
          count     = count + 16'd1;
          // the wire count includes skipped escapes; close once it reaches
          // or passes the length, so a bad length still ends the frame
          if (32'(count) + 32'(skips) >= len_word) begin
            r.kind      = KIND_LAST;
            r.length    = len_word[15:0];
            parse_state = PH_WAIT;
            count       = '0;
          end else begin
            r.kind = KIND_PAYLOAD;
          end
        end else begin
          skips = skips + 16'd1;
        end
      end else begin
        parse_state = PH_WAIT;
      end
      esc_pending = is_esc;
    end
  endtask

  // Offer one byte, hold it until taken, queue its expectation, then idle at random.
  task automatic send_byte(input logic [7:0] rx, input row_mode_t mode,
                           input frame_result_t given);
    frame_result_t r;
    bit            got;
    int            gap;
    in_tdata  <= rx;
    in_tvalid <= 1'b1;
    // in_tready follows out_tready combinationally: sample it mid-cycle
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    deframe_byte(rx, got, r);
    case (mode)
      ROW_GIVEN: pending_results.push_back(given);
      ROW_NONE:  ;
      default:   if (got) pending_results.push_back(r);
    endcase
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait out every expected result, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers in turn; hold cfg_we across the writes.
  task automatic load_settings(input logic [7:0] s, input logic [7:0] e,
                               input logic [15:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_wdata <= {8'h00, s};
    @(posedge clk);
    cfg_index <= CFG_ESCAPE_MARKER;
    cfg_wdata <= {8'h00, e};
    @(posedge clk);
    cfg_index <= CFG_LENGTH_LIMIT;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_we        <= 1'b0;
    marker_start  = s;
    marker_escape = e;
    limit_len     = l;
  endtask

  // Random byte, leaning on the two marker values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return marker_start;
      1:       return marker_escape;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append one logical byte in wire form: escape markers (and now and then an
  // ordinary byte). With equal markers no escape is possible, so bend the
  // byte off the marker instead.
  task automatic stuff_byte(ref logic [7:0] q[$], input logic [7:0] b);
    if (marker_start == marker_escape) begin
      if (b == marker_start) b = b ^ 8'h01;
      q.push_back(b);
    end else begin
      if (b == marker_start || b == marker_escape || $urandom_range(0, 15) == 0)
        q.push_back(marker_escape);
      q.push_back(b);
    end
  endtask

  // One random chunk: a frame (mostly well-formed) or a burst of line noise.
  task automatic send_chunk(output int n_sent);
    logic [7:0]  wire_q[$];
    logic [7:0]  body[$];
    logic [31:0] len;
    int          n_bytes;
    int          pick;
    int          cut;
    calm = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) wire_q.push_back(pick_byte());
    end else begin
      n_bytes = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                             : $urandom_range(1, 12);
      repeat (n_bytes) stuff_byte(body, pick_byte());
      len  = body.size();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // length too long: the frame runs into whatever follows
        len = len + $urandom_range(1, 3);
      end else if (pick < 14) begin
        // length too short: the tail falls on the idle line
        len = $urandom_range(1, len);
      end else if (pick < 20) begin
        case ($urandom_range(0, 2))
          0:       len = $urandom;
          1:       len = {16'h0000, limit_len} + $urandom_range(0, 40);
          default: len = 32'hFFFF_FFFF;
        endcase
      end else if (pick < 24) begin
        len = '0;
      end else if (pick < 30) begin
        // cut the frame short; the next start marker abandons it
        cut = $urandom_range(0, body.size() - 1);
        while (body.size() > cut) void'(body.pop_back());
      end
      wire_q.push_back(marker_start);
      for (int k = 0; k < LEN_BYTES; k++) stuff_byte(wire_q, len[8*k +: 8]);
      foreach (body[i]) wire_q.push_back(body[i]);
      if ($urandom_range(0, 3) == 0) wire_q.push_back(pick_byte());
    end
    foreach (wire_q[i]) send_byte(wire_q[i], ROW_PREDICT, NO_RESULT);
    n_sent = wire_q.size();
  endtask

  // Main sequence: reset, directed table, then random traffic per setting.
  initial begin
    int         sent;
    int         n;
    logic [7:0] s;
    logic [7:0] e;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_START_MARKER;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_byte(SCRIPT[i].rx, SCRIPT[i].mode, SCRIPT[i].given);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: load_settings(8'h00, 8'hFF, 16'hFFFF);
          2: load_settings(8'hFF, 8'h00, 16'd1);      // nearly all overflow
          3: load_settings(8'h5A, 8'h5A, 16'd300);    // equal markers
          4: begin
            s = 8'($urandom_range(0, 255));
            do e = 8'($urandom_range(0, 255)); while (e == s);
            load_settings(s, e, 16'($urandom_range(8, 40)));
          end
          default: load_settings(START_MARKER_RST, ESCAPE_MARKER_RST,
                                 LENGTH_LIMIT_RST);
        endcase
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_chunk(n);
        sent += n;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before each item.
  initial begin
    int hold;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!(out_tvalid && out_tready));
      @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // Check each result mid-cycle; the handshake completes at the next edge.
  always @(negedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_tuser));
        check_field("payload_byte", 16'(want.payload), 16'(out_tdata[7:0]));
        check_field("byte_offset", want.offset, out_tdata[23:8]);
        check_field("frame_length", want.length, out_tdata[39:24]);
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(negedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

endmodule
